/* src/pfla_pkg.sv */
// Package for the page free list allocator.
// Holds the shared page and status types, codes and the link memory request struct.
// No dependencies.
`timescale 1ns / 1ps

package pfla_pkg;

    localparam int unsigned PAGE_W = 10;
    localparam int unsigned LINK_DEPTH = 1 << PAGE_W;

    typedef logic [PAGE_W-1:0] t_page;
    typedef logic [1:0] t_status;

    localparam t_page PAGE_NULL = '0;
    localparam t_page PAGE_MAX = '1;
    localparam t_page PAGE_HEADER = t_page'(1);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE = 1'b1;

    localparam t_status ST_OK = 2'd0;
    localparam t_status ST_NULL_FREE = 2'd1;
    localparam t_status ST_OUT_OF_PAGES = 2'd2;
    localparam t_status ST_BAD_FREE = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    typedef struct packed {
        logic  en;
        logic  we;
        t_page addr;
        t_page wdata;
    } t_mem_req;

endpackage

/* src/pfla_link_mem.sv */
// Link memory of the page free list: one entry per page, holding the next page.
// Single port, synchronous read: the read data is registered. Uses pfla_pkg.
`timescale 1ns / 1ps

module pfla_link_mem (
    input  logic              i_clk,
    input  pfla_pkg::t_mem_req i_req,
    output pfla_pkg::t_page   o_rdata
);

    pfla_pkg::t_page r_mem [pfla_pkg::LINK_DEPTH];
    pfla_pkg::t_page r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            if (i_req.we) begin
                r_mem[i_req.addr] <= i_req.wdata;
            end else begin
                r_rdata <= r_mem[i_req.addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/page_free_list_allocator_unit.sv */
// Top level of the page free list allocator: control, head, count and high-water mark.
// Instantiates pfla_link_mem and uses pfla_pkg.
//
// Usage: a transaction on the input channel carries an operation (allocate or free)
// and a page number. Every input transaction yields exactly one output transaction
// with the allocated page, a status code and the number of pages on the free list.
// A free, an allocate that raises the high-water mark and any rejected request are
// answered directly: the result is registered and valid in the cycle after acceptance.
// An allocate that pops the free list reads the link of the head page from the
// single-port synchronous link memory in state S_READ; the input stalls during that
// read, so the block takes no new transaction before that allocate is answered.
// The output register holds a result while the receiver stalls; the block then
// stalls its input until that result is taken. Reset empties the free list, sets
// the high-water mark to the header page and clears the output valid. The link
// memory needs no clearing, since no entry is read before it is written.
// PAGE_LIMIT caps the high-water mark; values above the largest page number are clamped to it.
`timescale 1ns / 1ps

module page_free_list_allocator_unit #(
    parameter int unsigned PAGE_LIMIT = 1023
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [9:0]  i_page_number,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [9:0]  o_result_page,
    output logic [1:0]  o_status,
    output logic [9:0]  o_free_pages
);

    localparam int unsigned LIMIT_INT =
        (PAGE_LIMIT > (pfla_pkg::LINK_DEPTH - 1)) ? (pfla_pkg::LINK_DEPTH - 1) : PAGE_LIMIT;
    localparam pfla_pkg::t_page LIMIT = pfla_pkg::t_page'(LIMIT_INT);

    pfla_pkg::t_state   r_state, n_state;
    pfla_pkg::t_page    r_head, n_head;
    pfla_pkg::t_page    r_total, n_total;
    pfla_pkg::t_page    r_high, n_high;
    logic               r_out_valid, n_out_valid;
    pfla_pkg::t_page    r_res, n_res;
    pfla_pkg::t_status  r_st, n_st;
    pfla_pkg::t_page    r_free, n_free;

    pfla_pkg::t_mem_req mem_req;
    pfla_pkg::t_page    mem_rdata;
    logic               out_free;
    logic               accept;

    pfla_link_mem u_link_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == pfla_pkg::S_IDLE) && out_free);
    assign accept = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        n_head = r_head;
        n_total = r_total;
        n_high = r_high;
        n_out_valid = r_out_valid && i_out_stall;
        n_res = r_res;
        n_st = r_st;
        n_free = r_free;
        mem_req.en = 1'b0;
        mem_req.we = 1'b0;
        mem_req.addr = r_head;
        mem_req.wdata = r_head;

        unique case (r_state)
            pfla_pkg::S_IDLE: begin
                if (accept) begin
                    n_res = pfla_pkg::PAGE_NULL;
                    n_st = pfla_pkg::ST_OK;
                    n_free = r_total;
                    if (i_operation == pfla_pkg::OP_ALLOC) begin
                        if (r_total != '0) begin
                            mem_req.en = 1'b1;
                            n_state = pfla_pkg::S_READ;
                        end else if (r_high < LIMIT) begin
                            n_high = r_high + pfla_pkg::t_page'(1);
                            n_res = n_high;
                            n_out_valid = 1'b1;
                        end else begin
                            n_st = pfla_pkg::ST_OUT_OF_PAGES;
                            n_out_valid = 1'b1;
                        end
                    end else begin
                        n_out_valid = 1'b1;
                        if (i_page_number == pfla_pkg::PAGE_NULL) begin
                            n_st = pfla_pkg::ST_NULL_FREE;
                        end else if (i_page_number > r_high || r_total == pfla_pkg::PAGE_MAX) begin
                            n_st = pfla_pkg::ST_BAD_FREE;
                        end else begin
                            mem_req.en = 1'b1;
                            mem_req.we = 1'b1;
                            mem_req.addr = i_page_number;
                            n_head = i_page_number;
                            n_total = r_total + pfla_pkg::t_page'(1);
                            n_free = n_total;
                        end
                    end
                end
            end
            pfla_pkg::S_READ: begin
                if (out_free) begin
                    n_head = mem_rdata;
                    n_total = r_total - pfla_pkg::t_page'(1);
                    n_res = r_head;
                    n_st = pfla_pkg::ST_OK;
                    n_free = n_total;
                    n_out_valid = 1'b1;
                    n_state = pfla_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pfla_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfla_pkg::S_IDLE;
            r_head <= pfla_pkg::PAGE_NULL;
            r_total <= '0;
            r_high <= pfla_pkg::PAGE_HEADER;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head <= n_head;
            r_total <= n_total;
            r_high <= n_high;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_st <= n_st;
        r_free <= n_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_result_page = r_res;
    assign o_status = r_st;
    assign o_free_pages = r_free;

endmodule

/* src/pfla_checker.sv */
// Port-level checker for the page free list allocator, bound to the top level.
// Uses pfla_pkg for the status codes.
`timescale 1ns / 1ps

module pfla_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [9:0] o_result_page,
    input logic [1:0] o_status
);

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_page) && $stable(o_status))
        else $error("stalled output transaction changed");

    a_failure_has_null_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != pfla_pkg::ST_OK |-> o_result_page == '0)
        else $error("failed request returned a page");

    a_accept_makes_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid || o_in_stall)
        else $error("accepted transaction neither answered nor in progress");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind page_free_list_allocator_unit pfla_checker u_pfla_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_result_page (o_result_page),
    .o_status      (o_status)
);
